### src/packet_deframer_crc32_check_core_defines.svh
// Assertion macros for the packet deframer block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PACKET_DEFRAMER_CRC32_CHECK_CORE_DEFINES_SVH
`define PACKET_DEFRAMER_CRC32_CHECK_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PDC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PDC_ASSERT_IMPL(label, ante, cons)
`define PDC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/pdc_pkg.sv
// Shared types, constants and CRC function for the packet deframer.
// No dependencies.
`default_nettype none
package pdc_pkg;
    localparam int MAX_PAYLOAD_DEF = 512;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_HCRC = 3'd2;
    localparam logic [2:0] ST_PCRC = 3'd3;
    localparam logic [2:0] ST_LEN = 3'd4;

    // one result as it travels from the front part to the output stage
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [1:0]  ptype;
        logic        truncated;
        logic [4:0]  window;
        logic [9:0]  payload_length;
        logic [7:0]  seqnum;
        logic [31:0] timestamp;
        logic [31:0] header_crc;
        logic [31:0] payload_crc;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

### src/pdc_front.sv
// Front part: parses bytes, runs the CRC and forms one result per byte at most.
// Depends on pdc_pkg.
`default_nettype none
module pdc_front #(
    parameter int MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step,
    input  wire [7:0]            in_byte,
    input  wire                  in_last,
    input  wire [1:0]            data_type_code,
    output logic                 res_valid,
    output pdc_pkg::result_t     res
);
    import pdc_pkg::*;

    typedef enum logic [7:0] {
        PH_FIRST   = 8'b0000_0001,
        PH_LENGTH  = 8'b0000_0010,
        PH_SEQ     = 8'b0000_0100,
        PH_TIME    = 8'b0000_1000,
        PH_HCRC    = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_PCRC    = 8'b0100_0000,
        PH_SKIP    = 8'b1000_0000
    } phase_t;

    localparam int CW = $clog2(MAX_PAYLOAD + 1) > 2 ? $clog2(MAX_PAYLOAD + 1) : 2;

    phase_t phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0] crc_reg, crc_next;
    logic [1:0]  typ_reg, typ_next;
    logic        trn_reg, trn_next;
    logic [4:0]  win_reg, win_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next, hc_reg, hc_next, pc_reg, pc_next;
    logic [31:0] crc_upd;
    logic        st_fire;
    logic [2:0]  st_code;
    logic        pay_fire;
    logic        more;

    assign crc_upd = crc_byte(crc_reg, in_byte);
    assign more = !trn_reg && (len_reg != 16'd0);

    // parse one byte
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        crc_next = crc_reg;
        typ_next = typ_reg; trn_next = trn_reg; win_next = win_reg; len_next = len_reg;
        seq_next = seq_reg; ts_next = ts_reg; hc_next = hc_reg; pc_next = pc_reg;
        st_fire = 1'b0;
        st_code = ST_OK;
        pay_fire = 1'b0;
        case (phase_reg)
            PH_FIRST:
            begin
                typ_next = in_byte[7:6]; trn_next = in_byte[5]; win_next = in_byte[4:0];
                len_next = '0; seq_next = '0; ts_next = '0; hc_next = '0; pc_next = '0;
                crc_next = crc_byte(CRC_PRESET, in_byte & 8'hDF);
                cnt_next = '0;
                phase_next = (in_byte[7:6] == data_type_code) ? PH_LENGTH : PH_SEQ;
            end
            PH_LENGTH:
            begin
                crc_next = crc_upd;
                len_next = {len_reg[7:0], in_byte};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[0])
                begin
                    cnt_next = '0; phase_next = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                crc_next = crc_upd; seq_next = in_byte; cnt_next = '0; phase_next = PH_TIME;
            end
            PH_TIME:
            begin
                crc_next = crc_upd;
                ts_next[8*cnt_reg[1:0] +: 8] = in_byte;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next = '0; phase_next = PH_HCRC;
                end
            end
            PH_HCRC:
            begin
                hc_next = {hc_reg[23:0], in_byte};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next = '0;
                    if (~crc_reg != {hc_reg[23:0], in_byte})
                    begin
                        st_fire = 1'b1; st_code = ST_HCRC;
                    end
                    else if (32'(len_reg) > 32'(MAX_PAYLOAD))
                    begin
                        st_fire = 1'b1; st_code = ST_LEN;
                    end
                    else if (!more)
                    begin
                        st_fire = 1'b1; st_code = ST_OK;
                    end
                    else
                    begin
                        crc_next = CRC_PRESET; phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                crc_next = crc_upd;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) + 32'd1 >= 32'(len_reg))
                begin
                    cnt_next = '0; phase_next = PH_PCRC;
                end
                pay_fire = !in_last;
            end
            PH_PCRC:
            begin
                pc_next = {pc_reg[23:0], in_byte};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next = '0;
                    st_fire = 1'b1;
                    st_code = (~crc_reg == {pc_reg[23:0], in_byte}) ? ST_OK : ST_PCRC;
                end
            end
            PH_SKIP:
            begin
                if (in_last)
                begin
                    phase_next = PH_FIRST; cnt_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
        if (phase_reg != PH_SKIP)
        begin
            if (st_fire)
            begin
                phase_next = in_last ? PH_FIRST : PH_SKIP; cnt_next = '0;
            end
            else if (in_last)
            begin
                st_fire = 1'b1; st_code = ST_SHORT; pay_fire = 1'b0;
                phase_next = PH_FIRST; cnt_next = '0;
            end
        end
    end

    // form the result from the updated fields
    always_comb
    begin
        res = '0;
        res_valid = step && (st_fire || pay_fire);
        if (st_fire)
        begin
            res.kind = 1'b1;
            res.status = st_code;
            res.ptype = typ_next;
            res.truncated = trn_next;
            res.window = win_next;
            res.payload_length = (len_next > 16'd1023) ? 10'd1023 : len_next[9:0];
            res.seqnum = seq_next;
            res.timestamp = ts_next;
            res.header_crc = hc_next;
            res.payload_crc = pc_next;
        end
        else
        begin
            res.data_byte = in_byte;
        end
    end

    // advance state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST; cnt_reg <= '0; crc_reg <= CRC_PRESET;
            typ_reg <= '0; trn_reg <= 1'b0; win_reg <= '0; len_reg <= '0;
            seq_reg <= '0; ts_reg <= '0; hc_reg <= '0; pc_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; cnt_reg <= cnt_next; crc_reg <= crc_next;
            typ_reg <= typ_next; trn_reg <= trn_next; win_reg <= win_next;
            len_reg <= len_next; seq_reg <= seq_next; ts_reg <= ts_next;
            hc_reg <= hc_next; pc_reg <= pc_next;
        end
    end
endmodule
`default_nettype wire

### src/pdc_queue.sv
// Two-entry result queue between the front part and the output port.
// Depends on pdc_pkg and the assertion macro header.
`default_nettype none
`include "packet_deframer_crc32_check_core_defines.svh"
module pdc_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  pdc_pkg::result_t     push_data,
    output logic                 full,
    output logic                 out_valid,
    input  wire                  pop,
    output pdc_pkg::result_t     out_data
);
    import pdc_pkg::*;

    result_t     mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        do_pop;

    assign full = cnt_reg[1];
    assign out_valid = cnt_reg != 2'd0;
    assign out_data = mem_reg[rp_reg];
    assign do_pop = pop && out_valid;

    // hold queued results
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (do_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

    `PDC_ASSERT_IMPL(a_no_overflow, push, !full || do_pop)
    `PDC_ASSERT_IMPL(a_count_range, 1'b1, cnt_reg != 2'd3)
    `PDC_ASSERT_NEXT(a_empty_after, (cnt_reg == 2'd1) && do_pop && !push, !out_valid)
endmodule
`default_nettype wire

### src/packet_deframer_crc32_check_core.sv
// Top level of the packet deframer with header and payload CRC-32 checks.
// Depends on pdc_pkg, pdc_front and pdc_queue.
`default_nettype none
// One byte is taken per clock cycle, back to back, while in_stall is low; each
// byte yields at most one result (a payload byte or a closing status), which is
// registered in a two-entry queue. The parser's byte-wide CRC-32 update handles
// a whole byte at once. in_stall is high whenever the queue holds two results,
// which happens only after the output has been stalled; it drops the cycle
// after the output takes one. data_type_code is written through cfg_we/cfg_data.
module packet_deframer_crc32_check_core #(
    parameter int MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [1:0]   cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire [7:0]   in_byte,
    input  wire         in_last,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [2:0]  status,
    output logic [1:0]  ptype,
    output logic        truncated,
    output logic [4:0]  window,
    output logic [9:0]  payload_length,
    output logic [7:0]  seqnum,
    output logic [31:0] timestamp,
    output logic [31:0] header_crc,
    output logic [31:0] payload_crc
);
    import pdc_pkg::*;

    logic [1:0] dtc_reg;
    logic       full, step, res_valid;
    result_t    res, q;

    // hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dtc_reg <= 2'd1;
        else if (cfg_we) dtc_reg <= cfg_data;
    end

    assign in_stall = full;
    assign step = in_valid && !full;

    pdc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .clk(clk), .rst_n(rst_n), .step(step), .in_byte(in_byte), .in_last(in_last),
        .data_type_code(dtc_reg), .res_valid(res_valid), .res(res)
    );

    pdc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(res_valid), .push_data(res), .full(full),
        .out_valid(out_valid), .pop(!out_stall), .out_data(q)
    );

    assign kind = q.kind;
    assign data_byte = q.data_byte;
    assign status = q.status;
    assign ptype = q.ptype;
    assign truncated = q.truncated;
    assign window = q.window;
    assign payload_length = q.payload_length;
    assign seqnum = q.seqnum;
    assign timestamp = q.timestamp;
    assign header_crc = q.header_crc;
    assign payload_crc = q.payload_crc;
endmodule
`default_nettype wire
